[src/mtwq_pkg.sv]
// mtwq_pkg: shared constants, codes and types for the mutex table with wait queues
// no dependencies; used by the top level
`default_nettype none

package mtwq_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_MUTEXES_DEF = 8;
  localparam int MAX_THREADS_DEF = 8;

  // fixed field widths
  localparam int TID_W     = 3;
  localparam int MID_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_BLOCK     = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_BAD_ID    = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic {
    FN_ACQUIRE = 1'b0,
    FN_RELEASE = 1'b1
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTEX_COUNT  = 1'b1;

  localparam logic [CFG_W-1:0] THREAD_COUNT_RST = 4'd8;
  localparam logic [CFG_W-1:0] MUTEX_COUNT_RST  = 4'd8;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [TID_W-1:0] woken_thread;
    logic             woken_valid;
    status_t          status;
  } result_t;

endpackage

`default_nettype wire

[src/mutex_table_with_wait_queues.sv]
// mutex_table_with_wait_queues: mutex owner table with a fifo wait ring per mutex
// depends on mtwq_pkg and mtwq_ram
//
// channel  dir  signals                         beat contents (lowest bit first)
// in_      in   in_tvalid/in_tready/in_tdata    func, thread_id, mutex_id, pad
// out_     out  out_tvalid/out_tready/out_tdata status, woken_valid, woken_thread, pad
// cfg_     in   cfg_we/cfg_index/cfg_wdata      0 thread_count, 1 mutex_count
//
// one request at a time: each beat waits on the registered read of the mutex table ram
// and, on a release that hands over to a waiter, on the dependent read of the wait ring
// ram at the ring head
// rst_n is synchronous; table entries carry valid bits so no clearing pass is needed
// a full output register with out_tready low holds the request in its last step
`default_nettype none

module mutex_table_with_wait_queues #(
  parameter int MAX_MUTEXES = mtwq_pkg::MAX_MUTEXES_DEF,
  parameter int MAX_THREADS = mtwq_pkg::MAX_THREADS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [mtwq_pkg::TDATA_W-1:0]       in_tdata,   // func, thread_id, mutex_id
  // result
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [mtwq_pkg::TDATA_W-1:0]       out_tdata,  // status, woken_valid, woken_thread
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [mtwq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mtwq_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int TID_W  = mtwq_pkg::TID_W;
  localparam int MID_W  = mtwq_pkg::MID_W;
  localparam int MIW    = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;
  localparam int PW     = $clog2(MAX_THREADS);         // ring pointer
  localparam int CW     = $clog2(MAX_THREADS + 1);     // waiter count
  localparam int RDEPTH = MAX_MUTEXES * MAX_THREADS;
  localparam int RAW    = $clog2(RDEPTH);

  // one mutex table entry; free is the inverse of owner_valid
  typedef struct packed {
    logic             owner_valid;
    logic [TID_W-1:0] owner_thread;
    logic [PW-1:0]    head;
    logic [PW-1:0]    tail;
    logic [CW-1:0]    count;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_WAKE
  } state_t;

  state_t                   state_r, state_nxt;
  mtwq_pkg::func_t          func_r;
  logic [TID_W-1:0]         tid_r;
  logic [MID_W-1:0]         mid_r;
  logic [mtwq_pkg::CFG_W-1:0] thr_cfg_r, mtx_cfg_r;
  logic [MAX_MUTEXES-1:0]   tbl_vld_r;
  logic                     out_tvalid_r;
  mtwq_pkg::result_t        out_res_r;

  // ram ports
  logic                     tbl_we, tbl_re;
  logic [MIW-1:0]           tbl_raddr, tbl_idx;
  entry_t                   tbl_wdata;
  logic [EW-1:0]            tbl_rdata;
  logic                     ring_we, ring_re;
  logic [RAW-1:0]           ring_waddr, ring_raddr;
  logic [TID_W-1:0]         ring_wdata, ring_rdata;

  // lookup datapath
  logic [CW-1:0]            tc_c;
  logic                     bad_c, is_owner_c, out_free_c, res_load;
  entry_t                   ent_c;
  mtwq_pkg::result_t        res_nxt;

  // ring pointer step, wrapping at the effective thread count
  function automatic logic [PW-1:0] ring_adv(input logic [PW-1:0] p,
                                             input logic [CW-1:0] tc);
    logic [CW-1:0] p1;
    p1 = CW'(p) + CW'(1);
    return (p1 >= tc) ? '0 : PW'(p1);
  endfunction

  function automatic logic [RAW-1:0] ring_slot(input logic [MID_W-1:0] m,
                                               input logic [PW-1:0] p);
    return RAW'(32'(m) * MAX_THREADS + 32'(p));
  endfunction

  mtwq_ram #(.WIDTH(EW), .DEPTH(MAX_MUTEXES)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_idx),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  mtwq_ram #(.WIDTH(TID_W), .DEPTH(RDEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // effective thread count: zero reads as one, large values clamp
  always_comb begin
    if (thr_cfg_r == '0) begin
      tc_c = CW'(1);
    end else if (32'(thr_cfg_r) > MAX_THREADS) begin
      tc_c = CW'(MAX_THREADS);
    end else begin
      tc_c = CW'(thr_cfg_r);
    end
  end

  assign bad_c = (32'(mid_r) >= ((32'(mtx_cfg_r) > MAX_MUTEXES) ? 32'(MAX_MUTEXES)
                                                                 : 32'(mtx_cfg_r)))
              || (32'(tid_r) >= 32'(tc_c));

  assign tbl_idx    = MIW'(mid_r);
  // an entry never written reads as its reset value
  assign ent_c      = tbl_vld_r[tbl_idx] ? entry_t'(tbl_rdata) : '0;
  assign is_owner_c = ent_c.owner_valid && (ent_c.owner_thread == tid_r);
  assign out_free_c = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign tbl_re     = (state_r == S_IDLE) && in_tvalid;
  assign tbl_raddr  = MIW'(in_tdata[1+TID_W +: MID_W]);
  assign ring_waddr = ring_slot(mid_r, ent_c.tail);
  assign ring_raddr = ring_slot(mid_r, ent_c.head);
  assign ring_wdata = tid_r;

  // read, modify, write back of one table entry
  always_comb begin
    state_nxt = state_r;
    tbl_we    = 1'b0;
    tbl_wdata = ent_c;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    res_load  = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!bad_c && func_r == mtwq_pkg::FN_RELEASE && is_owner_c && ent_c.count != '0) begin
          // handover: fetch the oldest waiter first
          ring_re   = 1'b1;
          state_nxt = S_WAKE;
        end else if (out_free_c) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
          if (bad_c) begin
            res_nxt.status = mtwq_pkg::ST_BAD_ID;
          end else if (func_r == mtwq_pkg::FN_ACQUIRE) begin
            if (is_owner_c) begin
              res_nxt.status = mtwq_pkg::ST_ALREADY;
            end else if (!ent_c.owner_valid) begin
              tbl_we                 = 1'b1;
              tbl_wdata.owner_valid  = 1'b1;
              tbl_wdata.owner_thread = tid_r;
              res_nxt.status         = mtwq_pkg::ST_GRANTED;
            end else if (ent_c.count >= tc_c) begin
              res_nxt.status = mtwq_pkg::ST_FULL;
            end else begin
              // enqueue at the ring tail
              ring_we         = 1'b1;
              tbl_we          = 1'b1;
              tbl_wdata.tail  = ring_adv(ent_c.tail, tc_c);
              tbl_wdata.count = ent_c.count + CW'(1);
              res_nxt.status  = mtwq_pkg::ST_BLOCK;
            end
          end else if (is_owner_c) begin
            // release with nobody waiting
            tbl_we                 = 1'b1;
            tbl_wdata.owner_valid  = 1'b0;
            tbl_wdata.owner_thread = '0;
            res_nxt.status         = mtwq_pkg::ST_RELEASED;
          end else begin
            res_nxt.status = mtwq_pkg::ST_NOT_OWNER;
          end
        end
      end
      S_WAKE: begin
        if (out_free_c) begin
          tbl_we                 = 1'b1;
          tbl_wdata.owner_thread = ring_rdata;
          tbl_wdata.head         = ring_adv(ent_c.head, tc_c);
          tbl_wdata.count        = ent_c.count - CW'(1);
          res_load               = 1'b1;
          res_nxt.status         = mtwq_pkg::ST_RELEASED;
          res_nxt.woken_valid    = 1'b1;
          res_nxt.woken_thread   = ring_rdata;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      tbl_vld_r    <= '0;
      thr_cfg_r    <= mtwq_pkg::THREAD_COUNT_RST;
      mtx_cfg_r    <= mtwq_pkg::MUTEX_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mtwq_pkg::CFG_THREAD_COUNT: thr_cfg_r <= cfg_wdata;
          mtwq_pkg::CFG_MUTEX_COUNT:  mtx_cfg_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (tbl_we) begin
        tbl_vld_r[tbl_idx] <= 1'b1;
      end
      // capture request fields on the accepted beat
      if (tbl_re) begin
        func_r <= mtwq_pkg::func_t'(in_tdata[0]);
        tid_r  <= in_tdata[1 +: TID_W];
        mid_r  <= in_tdata[1+TID_W +: MID_W];
      end
      // output register parts the result side from the table update
      if (res_load) begin
        out_tvalid_r <= 1'b1;
        out_res_r    <= res_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(mtwq_pkg::TDATA_W - $bits(mtwq_pkg::result_t)){1'b0}}, out_res_r};

  // a woken thread only ever comes with a release
  a_woken_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_res_r.woken_valid |-> out_res_r.status == mtwq_pkg::ST_RELEASED)
    else $error("woken thread reported without a release");

  // an accepted beat always goes on to the table lookup
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> state_r == S_LOOKUP)
    else $error("accepted beat did not start a lookup");

  // the wake step follows the ring read issued from the lookup
  a_wake_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WAKE |-> $past(state_r) == S_LOOKUP || $past(state_r) == S_WAKE)
    else $error("wake step entered without a ring read");

  // table writes only happen once read data is at hand
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> state_r != S_IDLE)
    else $error("table written while idle");

  // a ring never holds more waiters than it has slots, and never enqueues and dequeues together
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> 32'(tbl_wdata.count) <= MAX_THREADS && !(ring_we && ring_re))
    else $error("wait ring overfilled or enqueue and dequeue together");

endmodule

`default_nettype wire

[src/mtwq_ram.sv]
// mtwq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mtwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[test/mtwq_checker.sv]
// mtwq_checker: beat monitor and scoreboard for the mutex table with wait queues
// depends on mtwq_pkg; mirrors the lock table so the stimulus can aim its releases
module mtwq_checker
  import mtwq_pkg::*;
(
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [TDATA_W-1:0]                    in_tdata,   // func, thread_id, mutex_id
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [TDATA_W-1:0]                    out_tdata,  // status, woken_valid, woken_thread
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_wdata,
  output int                                    failures,
  output int                                    outstanding,
  output int                                    replies_checked,
  output logic [6:0]                            status_hit,
  output logic [MAX_MUTEXES_DEF-1:0]            held,
  output logic [MAX_MUTEXES_DEF-1:0][TID_W-1:0] holder
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NM = MAX_MUTEXES_DEF;
  localparam int NT = MAX_THREADS_DEF;

  logic [CFG_W-1:0] thread_reg;
  logic [CFG_W-1:0] mutex_reg;
  bit               lock_free  [NM];
  bit               lock_owned [NM];
  logic [TID_W-1:0] lock_owner [NM];
  int               ring_head  [NM];
  int               ring_tail  [NM];
  int               ring_depth [NM];
  logic [TID_W-1:0] ring_slot  [NM][NT];
  result_t          pending_replies[$];

  initial begin
    failures = 0;
    replies_checked = 0;
    status_hit = '0;
    outstanding = 0;
    held = '0;
    holder = '0;
  end

  function automatic int next_ptr(int p, int nt);
    return (p + 1 >= nt) ? 0 : p + 1;
  endfunction

  // lock table behaviour for one request, updating the mirror
  function automatic result_t apply_request(func_t fn, logic [TID_W-1:0] tid,
                                            logic [MID_W-1:0] mid);
    result_t r;
    int nt, nm, m, t;
    nt = (thread_reg == 0) ? 1 : ((thread_reg > NT) ? NT : int'(thread_reg));
    nm = (mutex_reg > NM) ? NM : int'(mutex_reg);
    m = mid;
    t = tid;
    r.status = ST_BAD_ID;
    r.woken_valid = 1'b0;
    r.woken_thread = '0;
    if (m >= nm || t >= nt) return r;
    if (fn == FN_ACQUIRE) begin
      if (lock_owned[m] && lock_owner[m] == tid) begin
        r.status = ST_ALREADY;
      end else if (lock_free[m]) begin
        lock_free[m] = 1'b0;
        lock_owned[m] = 1'b1;
        lock_owner[m] = tid;
        r.status = ST_GRANTED;
      end else if (ring_depth[m] >= nt) begin
        r.status = ST_FULL;
      end else begin
        ring_slot[m][ring_tail[m] % NT] = tid;
        ring_tail[m] = next_ptr(ring_tail[m], nt);
        ring_depth[m]++;
        r.status = ST_BLOCK;
      end
    end else if (lock_owned[m] && lock_owner[m] == tid) begin
      r.status = ST_RELEASED;
      if (ring_depth[m] > 0) begin
        // oldest waiter takes the lock over
        r.woken_valid = 1'b1;
        r.woken_thread = ring_slot[m][ring_head[m] % NT];
        ring_head[m] = next_ptr(ring_head[m], nt);
        ring_depth[m]--;
        lock_owner[m] = r.woken_thread;
      end else begin
        lock_free[m] = 1'b1;
        lock_owned[m] = 1'b0;
        lock_owner[m] = '0;
      end
    end else begin
      r.status = ST_NOT_OWNER;
    end
    return r;
  endfunction

  function automatic void report(string what, int want, int got);
    failures++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      thread_reg = THREAD_COUNT_RST;
      mutex_reg = MUTEX_COUNT_RST;
      for (int m = 0; m < NM; m++) begin
        lock_free[m] = 1'b1;
        lock_owned[m] = 1'b0;
        lock_owner[m] = '0;
        ring_head[m] = 0;
        ring_tail[m] = 0;
        ring_depth[m] = 0;
      end
      pending_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THREAD_COUNT: thread_reg = cfg_wdata;
          CFG_MUTEX_COUNT:  mutex_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_replies.push_back(apply_request(func_t'(in_tdata[0]),
                                                in_tdata[TID_W:1],
                                                in_tdata[TID_W+MID_W:TID_W+1]));
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (pending_replies.size() == 0) begin
          report("unexpected beat, status", -1, got.status);
        end else begin
          want = pending_replies.pop_front();
          replies_checked++;
          status_hit[want.status] = 1'b1;
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.woken_valid !== want.woken_valid)
            report("woken_valid", want.woken_valid, got.woken_valid);
          if (got.woken_thread !== want.woken_thread)
            report("woken_thread", want.woken_thread, got.woken_thread);
        end
      end
    end
    // mirrors for the stimulus side, visible from the next edge
    outstanding <= pending_replies.size();
    for (int m = 0; m < NM; m++) begin
      held[m] <= lock_owned[m];
      holder[m] <= lock_owner[m];
    end
  end

endmodule

[test/tb_mutex_table_with_wait_queues.sv]
// tb_mutex_table_with_wait_queues: request stimulus and verdict for the mutex table
// depends on mtwq_pkg, mutex_table_with_wait_queues and mtwq_checker
module tb_mutex_table_with_wait_queues;
  timeunit 1ns;
  timeprecision 1ps;
  import mtwq_pkg::*;

  localparam int NM = MAX_MUTEXES_DEF;
  localparam int NT = MAX_THREADS_DEF;
  localparam int SEGMENTS = 8;
  localparam int HOLD_CYCLES = 200;     // long receiver stall to back the block up
  localparam int CYCLE_LIMIT = 250000;  // several times the slowest legal run

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;     // func, thread_id, mutex_id
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;         // status, woken_valid, woken_thread
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int                          failures;
  int                          outstanding;
  int                          replies_checked;
  logic [6:0]                  status_hit;
  logic [NM-1:0]               held;
  logic [NM-1:0][TID_W-1:0]    holder;

  int tx_idle_pct = 6;
  int rx_idle_pct = 50;
  int holds_asked = 0;
  int holds_served = 0;
  int requests_sent = 0;
  int settings_used = 0;
  int threads_used = NT;
  int mutexes_used = NM;
  int cycle_count = 0;

  mutex_table_with_wait_queues uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mtwq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .failures        (failures),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .status_hit      (status_hit),
    .held            (held),
    .holder          (holder)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one request beat, with an occasional gap in front of it
  task automatic send(func_t fn, int t, int m);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, MID_W'(m), TID_W'(t), fn};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // stop offering and wait until every reply has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // hand every held lock back so no thread is left waiting before a retune
  task automatic free_all();
    settle();
    for (int m = 0; m < NM; m++) begin
      while (held[m]) begin
        send(FN_RELEASE, holder[m], m);
        settle();
      end
    end
    repeat (4) @(posedge clk);
  endtask

  // both registers in back-to-back beats; block is idle here
  task automatic configure(int tc, int mc);
    cfg_we <= 1'b1;
    cfg_index <= CFG_THREAD_COUNT;
    cfg_wdata <= CFG_W'(tc);
    @(posedge clk);
    cfg_index <= CFG_MUTEX_COUNT;
    cfg_wdata <= CFG_W'(mc);
    @(posedge clk);
    cfg_we <= 1'b0;
    threads_used = (tc == 0) ? 1 : ((tc > NT) ? NT : tc);
    mutexes_used = (mc > NM) ? NM : mc;
    settings_used++;
  endtask

  // mostly well-formed traffic on a few hot locks, with some noise
  task automatic random_request();
    int m, t, hot;
    func_t fn;
    if (mutexes_used == 0 || $urandom_range(99) < 8) begin
      m = $urandom_range(NM - 1);
    end else if ($urandom_range(1) == 1) begin
      hot = (mutexes_used < 2) ? mutexes_used - 1 : 1;
      m = $urandom_range(hot);
    end else begin
      m = $urandom_range(mutexes_used - 1);
    end
    t = ($urandom_range(99) < 8) ? $urandom_range(NT - 1) : $urandom_range(threads_used - 1);
    if (held[m] && $urandom_range(99) < 40) begin
      fn = FN_RELEASE;
      t = holder[m];
    end else begin
      fn = ($urandom_range(99) < 15) ? FN_RELEASE : FN_ACQUIRE;
    end
    send(fn, t, m);
  endtask

  initial begin
    int waiters[8] = '{0, 1, 2, 3, 4, 6, 7, 0};
    int tc_set[SEGMENTS] = '{2, 0, 15, 8, 3, 1, 5, 8};
    int mc_set[SEGMENTS] = '{3, 8, 15, 0, 8, 1, 12, 2};
    int s, n, count;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: grant, re-acquire by owner, queue, release by non-owners, handover in order, free
    send(FN_ACQUIRE, 0, 0);
    send(FN_ACQUIRE, 0, 0);
    send(FN_ACQUIRE, 1, 0);
    send(FN_ACQUIRE, 2, 0);
    send(FN_RELEASE, 3, 0);   // not the owner
    send(FN_RELEASE, 0, 0);   // wakes thread 1
    send(FN_RELEASE, 1, 0);   // wakes thread 2
    send(FN_RELEASE, 2, 0);   // nobody waits, lock goes free
    send(FN_RELEASE, 2, 0);   // release of a free lock
    send(FN_ACQUIRE, 7, 7);
    send(FN_RELEASE, 7, 7);
    // fill one wait ring to the thread count, then overflow it
    send(FN_ACQUIRE, 5, 3);
    foreach (waiters[i]) send(FN_ACQUIRE, waiters[i], 3);
    send(FN_ACQUIRE, 1, 3);

    for (s = 0; s < SEGMENTS; s++) begin
      free_all();
      // idling pattern: sender light/receiver heavy, then swapped, then none
      if (s < 3) begin
        tx_idle_pct = 6;
        rx_idle_pct = 50;
      end else if (s < 6) begin
        tx_idle_pct = 50;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(tc_set[s], mc_set[s]);
      // a long receiver hold while requests keep coming, backs the block up
      if (s == 1) holds_asked++;
      count = (mc_set[s] == 0) ? 40 : 160;
      for (n = 0; n < count; n++) random_request();
    end

    settle();
    repeat (12) @(posedge clk);

    $display("%0d requests over %0d register settings, %0d replies checked",
             requests_sent, settings_used, replies_checked);
    $display("status codes returned, one bit per code from granted up: %b", status_hit);
    if (failures == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
